// ===== rtl/dtp_pkg.sv =====
// Shared types and constants for the dual throttle plausibility core.
package dtp_pkg;

  // Field widths of the stream payloads
  localparam int CODE_W    = 16;
  localparam int FRAC_BITS = 16;
  localparam int NORM_W    = FRAC_BITS + 1;
  localparam int TIME_W    = 32;
  localparam int PERSIST_W = 16;
  localparam int TOL_W     = 17;

  // Configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int ADC_BITS_DEF = 16;

  // Full scale in Q1.16
  localparam logic [NORM_W-1:0] ONE_Q16 = NORM_W'(1) << FRAC_BITS;

  // Register reset values
  localparam logic [CODE_W-1:0]    MIN_CODE_RST = 16'd9930;
  localparam logic [CODE_W-1:0]    MAX_CODE_RST = 16'd65535;
  localparam logic [TOL_W-1:0]     TOL_RST      = 17'd6554;
  localparam logic [PERSIST_W-1:0] PERSIST_RST  = 16'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_A   = 3'd0,
    REG_MAX_A   = 3'd1,
    REG_MIN_B   = 3'd2,
    REG_MAX_B   = 3'd3,
    REG_TOL     = 3'd4,
    REG_PERSIST = 3'd5
  } cfg_reg_t;

  // Status of the plausibility checker
  typedef struct packed {
    logic agree;
    logic fault;
  } chk_status_t;

endpackage

// ===== rtl/dtp_div.sv =====
// Bit-serial normaliser: (code - lo) * 2^16 / (hi - lo), clamped to 0..2^16, one quotient bit per cycle.
module dtp_div
  import dtp_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ADC_BITS-1:0] code,
  input  logic [ADC_BITS-1:0] lo,
  input  logic [ADC_BITS-1:0] hi,
  output logic                done,
  output logic [NORM_W-1:0]   quot
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [ADC_BITS-1:0] rem;
  logic [ADC_BITS-1:0] den;
  logic [ADC_BITS:0]   shifted;
  logic [ADC_BITS:0]   trial;
  logic                qbit;

  // One restoring step: shift the partial remainder, try the divisor
  always_comb begin
    shifted = {rem, 1'b0};
    trial   = shifted - {1'b0, den};
    qbit    = (shifted >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      quot <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // Clamp cases settle at once, else prime the remainder
        priority if (hi <= lo || code <= lo) begin
          quot <= '0;
          done <= 1'b1;
        end else if (code >= hi) begin
          quot <= ONE_Q16;
          done <= 1'b1;
        end else begin
          rem  <= code - lo;
          den  <= hi - lo;
          quot <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= qbit ? trial[ADC_BITS-1:0] : shifted[ADC_BITS-1:0];
        quot <= {quot[NORM_W-2:0], qbit};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/dtp_check.sv =====
// Plausibility state: tolerance compare, mismatch timing and fault latch.
module dtp_check
  import dtp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 check_en,
  input  logic [NORM_W-1:0]    cand_a,
  input  logic [NORM_W-1:0]    cand_b,
  input  logic [TOL_W-1:0]     tolerance,
  input  logic [PERSIST_W-1:0] persist_ms,
  input  logic [TIME_W-1:0]    now_ms,
  output chk_status_t          status
);

  logic              agree;
  logic              pending;
  logic              latched;
  logic              fault;
  logic [TIME_W-1:0] start_ms;
  logic [NORM_W-1:0] diff;
  logic [TIME_W-1:0] elapsed;
  logic              within_tol;
  logic              timed_out;

  // Absolute difference and elapsed mismatch time, modulo 2^32
  always_comb begin
    diff       = (cand_a >= cand_b) ? (cand_a - cand_b) : (cand_b - cand_a);
    within_tol = (diff <= tolerance);
    elapsed    = now_ms - start_ms;
    timed_out  = (elapsed >= TIME_W'(persist_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agree    <= 1'b1;
      pending  <= 1'b0;
      latched  <= 1'b0;
      fault    <= 1'b0;
      start_ms <= '0;
    end else if (check_en) begin
      fault <= 1'b0;
      priority if (within_tol) begin
        agree   <= 1'b1;
        pending <= 1'b0;
        latched <= 1'b0;
      end else if (!pending) begin
        pending  <= 1'b1;
        start_ms <= now_ms;
      end else if (timed_out) begin
        agree <= 1'b0;
        if (!latched) begin
          latched <= 1'b1;
          fault   <= 1'b1;
        end
      end
    end
  end

  assign status = '{agree: agree, fault: fault};

endmodule

// ===== rtl/dual_throttle_plausibility_core.sv =====
// Top level: stream ports, configuration registers and item sequencer.
// A window item passes divide A, divide B, check and output, sooner when a channel
// clamps; a non-window item skips the divider and passes only check and output.
// Throughput: one item at a time; the shared bit-serial divider runs channel A
// then channel B, and a new input beat is taken only back in the idle state.
// Reset (rst, synchronous): registers to defaults, plausible set, no fault pending.
module dual_throttle_plausibility_core
  import dtp_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input beats
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // raw_a[15:0], raw_b[31:16], now_ms[63:32]
  input  logic                  s_tuser,   // new_window
  // Result beats
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // norm_a[16:0], norm_b[33:17], zero pad
  output logic [1:0]            m_tuser,   // plausible[0], fault_event[1]
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_A,
    S_DIV_B,
    S_CHECK,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [ADC_BITS-1:0]  min_a, max_a, min_b, max_b;
  logic [TOL_W-1:0]     tolerance;
  logic [PERSIST_W-1:0] persist_ms;

  // Item latch and stored values
  logic [CODE_W-1:0] raw_a, raw_b;
  logic [TIME_W-1:0] now_ms;
  logic [NORM_W-1:0] cand_a, cand_b, held_a, held_b;

  logic                div_start;
  logic                div_done;
  logic [NORM_W-1:0]   div_quot;
  logic [ADC_BITS-1:0] div_code, div_lo, div_hi;
  logic                check_en;
  chk_status_t         status;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign check_en  = (state == S_CHECK);

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      min_a      <= MIN_CODE_RST[ADC_BITS-1:0];
      max_a      <= MAX_CODE_RST[ADC_BITS-1:0];
      min_b      <= MIN_CODE_RST[ADC_BITS-1:0];
      max_b      <= MAX_CODE_RST[ADC_BITS-1:0];
      tolerance  <= TOL_RST;
      persist_ms <= PERSIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_A:   min_a      <= cfg_data[ADC_BITS-1:0];
        REG_MAX_A:   max_a      <= cfg_data[ADC_BITS-1:0];
        REG_MIN_B:   min_b      <= cfg_data[ADC_BITS-1:0];
        REG_MAX_B:   max_b      <= cfg_data[ADC_BITS-1:0];
        REG_TOL:     tolerance  <= cfg_data;
        REG_PERSIST: persist_ms <= cfg_data[PERSIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider operands follow the channel being worked on
  always_comb begin
    if (state == S_DIV_B) begin
      div_code = raw_b[ADC_BITS-1:0];
      div_lo   = min_b;
      div_hi   = max_b;
    end else begin
      div_code = raw_a[ADC_BITS-1:0];
      div_lo   = min_a;
      div_hi   = max_a;
    end
  end

  dtp_div #(
    .ADC_BITS(ADC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .code  (div_code),
    .lo    (div_lo),
    .hi    (div_hi),
    .done  (div_done),
    .quot  (div_quot)
  );

  dtp_check u_check (
    .clk        (clk),
    .rst        (rst),
    .check_en   (check_en),
    .cand_a     (cand_a),
    .cand_b     (cand_b),
    .tolerance  (tolerance),
    .persist_ms (persist_ms),
    .now_ms     (now_ms),
    .status     (status)
  );

  // Sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
      cand_a    <= '0;
      cand_b    <= '0;
      held_a    <= '0;
      held_b    <= '0;
    end else begin
      // Accepted beat drops unless the output state loads the next one
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          div_start <= s_tvalid && s_tuser;
          if (s_tvalid) begin
            raw_a     <= s_tdata[15:0];
            raw_b     <= s_tdata[31:16];
            now_ms    <= s_tdata[63:32];
            state     <= s_tuser ? S_DIV_A : S_CHECK;
          end
        end
        S_DIV_A: begin
          div_start <= div_done;
          if (div_done) begin
            cand_a    <= div_quot;
            state     <= S_DIV_B;
          end
        end
        S_DIV_B: begin
          div_start <= 1'b0;
          if (div_done) begin
            // Exposed values gate on the plausibility before this item
            cand_b <= div_quot;
            held_a <= status.agree ? cand_a : '0;
            held_b <= status.agree ? div_quot : '0;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          div_start <= 1'b0;
          state     <= S_OUT;
        end
        S_OUT: begin
          div_start <= 1'b0;
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, held_b, held_a};
            m_tuser  <= {status.fault, status.agree};
            state    <= S_IDLE;
          end
        end
        default: begin
          div_start <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A fault beat always reports the pair as implausible
  a_fault_implausible: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[1] && m_tuser[0]))
    else $error("fault beat reports plausible");

  // Normalised values never exceed full scale
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[16] && (|m_tdata[15:0])) && !(m_tdata[33] && (|m_tdata[32:17])))
    else $error("normalised value above full scale");

  // The divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_A || state == S_DIV_B))
    else $error("divider done outside a divide state");

  // A new result beat follows the output state
  a_out_from_state: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT))
    else $error("result beat raised outside the output state");
`endif

endmodule
